// File: rtl/core/mmpn_pkg.sv
// shared types and constants of the min-max pixel normalizer
package mmpn_pkg;

   localparam int PIXEL_W = 8;
   localparam int NORM_W  = 17;

   // commands from the controller to the datapath
   typedef struct packed {
      logic scan;      // scan-pass beat accepted
      logic norm;      // normalize-pass beat accepted, load the divider
      logic step;      // one quotient bit
      logic load_out;  // move the finished result into the output register
   } mmpn_cmd_type;

endpackage

// File: rtl/core/mmpn_datapath.sv
// min/max tracking, frame latch, bit-serial divider and output register
module mmpn_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mmpn_pkg::mmpn_cmd_type            cmd,
   input  logic [mmpn_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                              req_last,
   output logic                              div_done,
   output logic [mmpn_pkg::NORM_W-1:0]       rsp_norm_value,
   output logic                              rsp_flat_range,
   output logic                              rsp_clipped
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam int PW    = mmpn_pkg::PIXEL_W;
   localparam int NW    = mmpn_pkg::NORM_W;

   logic [PW-1:0]  scan_low_ff, scan_low_in;
   logic [PW-1:0]  scan_high_ff, scan_high_in;
   logic [PW-1:0]  frame_low_ff, frame_low_in;
   logic [PW-1:0]  frame_range_ff, frame_range_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           sub_en_ff, sub_en_in;
   logic [PW-1:0]  rem_ff, rem_in;
   logic [NW-1:0]  quo_ff, quo_in;
   logic           flat_ff, flat_in;
   logic           clip_ff, clip_in;
   logic [NW-1:0]  out_value_ff;
   logic           out_flat_ff;
   logic           out_clip_ff;

   logic [PW-1:0]  run_low;
   logic [PW-1:0]  run_high;
   logic [PW:0]    span_top;
   logic           below;
   logic           above;
   logic           flat;
   logic           in_span;
   logic [PW-1:0]  diff;
   logic           quo_top;
   logic [PW:0]    rem_dbl;
   logic           ge;

   // running min/max including the current pixel
   assign run_low  = (req_pixel < scan_low_ff)  ? req_pixel : scan_low_ff;
   assign run_high = (req_pixel > scan_high_ff) ? req_pixel : scan_high_ff;

   // span classification against the latched frame
   assign span_top = {1'b0, frame_low_ff} + {1'b0, frame_range_ff};
   assign flat     = (frame_range_ff == '0);
   assign below    = (req_pixel < frame_low_ff);
   assign above    = ({1'b0, req_pixel} > span_top);
   assign in_span  = !flat && !below && !above;
   assign diff     = req_pixel - frame_low_ff;
   assign quo_top  = in_span && (diff == frame_range_ff);

   // restoring division step, remainder stays below the range
   assign rem_dbl = {rem_ff, 1'b0};
   assign ge      = sub_en_ff && (rem_dbl >= {1'b0, frame_range_ff});

   assign div_done = (cnt_ff == '0);

   always_comb begin
      scan_low_in    = scan_low_ff;
      scan_high_in   = scan_high_ff;
      frame_low_in   = frame_low_ff;
      frame_range_in = frame_range_ff;
      cnt_in         = cnt_ff;
      sub_en_in      = sub_en_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      flat_in        = flat_ff;
      clip_in        = clip_ff;
      if (cmd.scan) begin
         if (req_last) begin
            frame_low_in   = run_low;
            frame_range_in = run_high - run_low;
            scan_low_in    = '1;
            scan_high_in   = '0;
         end else begin
            scan_low_in  = run_low;
            scan_high_in = run_high;
         end
      end
      if (cmd.norm) begin
         // out-of-span cases ride the same shift: 1 << FRAC_BITS or 0
         cnt_in    = CNT_W'(FRAC_BITS);
         sub_en_in = in_span;
         rem_in    = (in_span && !quo_top) ? diff : '0;
         quo_in    = NW'(quo_top || (!flat && above));
         flat_in   = flat;
         clip_in   = !flat && (below || above);
      end
      if (cmd.step) begin
         cnt_in = cnt_ff - CNT_W'(1);
         rem_in = ge ? PW'(rem_dbl - {1'b0, frame_range_ff}) : rem_dbl[PW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_low_ff    <= '1;
         scan_high_ff   <= '0;
         frame_low_ff   <= '0;
         frame_range_ff <= '0;
         cnt_ff         <= '0;
         sub_en_ff      <= 1'b0;
      end else begin
         scan_low_ff    <= scan_low_in;
         scan_high_ff   <= scan_high_in;
         frame_low_ff   <= frame_low_in;
         frame_range_ff <= frame_range_in;
         cnt_ff         <= cnt_in;
         sub_en_ff      <= sub_en_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      flat_ff <= flat_in;
      clip_ff <= clip_in;
      if (cmd.load_out) begin
         out_value_ff <= quo_ff;
         out_flat_ff  <= flat_ff;
         out_clip_ff  <= clip_ff;
      end
   end

   assign rsp_norm_value = out_value_ff;
   assign rsp_flat_range = out_flat_ff;
   assign rsp_clipped    = out_clip_ff;

   a_rem_below_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sub_en_ff) |-> (rem_ff < frame_range_ff))
      else $error("divider remainder reached the range");

   a_flat_not_clip: assert property (@(posedge clock) disable iff (reset)
      cmd.norm |=> !(flat_ff && clip_ff))
      else $error("flat and clipped set together");

endmodule

// File: rtl/core/mmpn_ctrl.sv
// handshake control and sequencing of the normalizer
module mmpn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   div_done,
   output mmpn_pkg::mmpn_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.scan     = accept && !req_action;
      cmd.norm     = accept && req_action;
      cmd.step     = (state_ff == ST_RUN) && !div_done;
      cmd.load_out = (state_ff == ST_RUN) && div_done && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.norm) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cmd.load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_after_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> div_done)
      else $error("result loaded before the divider finished");

   a_valid_from_divider: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(div_done))
      else $error("result raised without a finished division");

endmodule

// File: rtl/core/min_max_pixel_normalizer_top.sv
// top level of the min-max pixel normalizer
// usage:
//   input beats (req_*) carry action, pixel and last. action 0 is a scan-pass
//   pixel: it updates the running min and max in the cycle it is accepted and
//   gives no result. a scan beat with last set closes the frame: the min and
//   the range (max - min) are latched and the running pair starts over.
//   action 1 is a normalize-pass pixel: it gives one result beat (rsp_*) with
//   floor((pixel - min) * 2^FRAC_BITS / range), saturated to 0 or 2^FRAC_BITS
//   with rsp_clipped when outside the span, and 0 with rsp_flat_range when
//   the range is zero. the value is kept to 17 bits.
// sequencing:
//   scan beats are taken one per cycle while no normalize beat is busy. a
//   normalize beat runs a bit-serial restoring divider, one quotient bit per
//   cycle; req_ready stays low until its result is moved into the output
//   register, so the next beat waits until then.
// reset: running min 255, max 0, latched min and range 0, no result pending.
// stall: the result waits in the output register while rsp_ready is low; the
//   next beat is still taken, a second normalize beat holds its finished
//   quotient until the output register is free
module min_max_pixel_normalizer_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [mmpn_pkg::PIXEL_W-1:0]  req_pixel,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mmpn_pkg::NORM_W-1:0]   rsp_norm_value,
   output logic                          rsp_flat_range,
   output logic                          rsp_clipped
);

   // command and status between controller and datapath
   mmpn_pkg::mmpn_cmd_type cmd;
   logic                   div_done;

   // controller: handshake, divider sequencing, output beat valid
   mmpn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .div_done   (div_done),
      .cmd        (cmd)
   );

   // datapath: min/max, frame latch, divider, output register
   mmpn_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_pixel      (req_pixel),
      .req_last       (req_last),
      .div_done       (div_done),
      .rsp_norm_value (rsp_norm_value),
      .rsp_flat_range (rsp_flat_range),
      .rsp_clipped    (rsp_clipped)
   );

endmodule

// File: sim/testbench.sv
// self-checking testbench of the min-max pixel normalizer
module testbench;

   localparam int FRAC_BITS      = 16;
   localparam int PIX_W          = mmpn_pkg::PIXEL_W;
   localparam int VAL_W          = mmpn_pkg::NORM_W;
   // time one normalize beat occupies the divider, used to size the final wait
   localparam int NORM_CYCLES    = FRAC_BITS + 2;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_BEATS    = 125;
   localparam int MAX_REPORTS    = 100;

   // values of req_action
   localparam logic ACT_SCAN = 1'b0;
   localparam logic ACT_NORM = 1'b1;

   // one result beat as it should appear on rsp_*
   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             flat;
      logic             clip;
   } norm_beat_type;

   // tracks the running and latched min/range and queues the results they imply
   class norm_scoreboard_type;
      logic [PIX_W-1:0] run_low;
      logic [PIX_W-1:0] run_high;
      logic [PIX_W-1:0] span_low;
      logic [PIX_W-1:0] span_width;
      norm_beat_type    pending_norms[$];
      int               errors;
      int               scan_beats;
      int               norm_beats;
      int               clip_beats;
      int               flat_beats;

      function new();
         run_low    = '1;
         run_high   = '0;
         span_low   = '0;
         span_width = '0;
         errors     = 0;
         scan_beats = 0;
         norm_beats = 0;
         clip_beats = 0;
         flat_beats = 0;
      endfunction

      function int pending();
         return pending_norms.size();
      endfunction

      task report_mismatch(input string what);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("mismatch: %s", what);
      endtask

      // scaled position of a pixel inside the latched span
      function norm_beat_type norm_of(input logic [PIX_W-1:0] pix);
         norm_beat_type r;
         logic [8:0]    top;
         logic [31:0]   diff;
         logic [31:0]   quot;
         r    = '0;
         top  = {1'b0, span_low} + {1'b0, span_width};
         diff = {24'd0, pix} - {24'd0, span_low};
         if (span_width == 0) begin
            r.flat = 1'b1;
         end else if (pix < span_low) begin
            r.clip = 1'b1;
         end else if ({1'b0, pix} > top) begin
            quot    = 32'd1 << FRAC_BITS;
            r.value = quot[VAL_W-1:0];
            r.clip  = 1'b1;
         end else begin
            quot    = (diff << FRAC_BITS) / {24'd0, span_width};
            r.value = quot[VAL_W-1:0];
         end
         return r;
      endfunction

      task note_pixel(input logic act, input logic [PIX_W-1:0] pix, input logic lst);
         norm_beat_type r;
         if (act == ACT_SCAN) begin
            scan_beats++;
            if (pix < run_low)
               run_low = pix;
            if (pix > run_high)
               run_high = pix;
            if (lst) begin
               span_low   = run_low;
               span_width = run_high - run_low;
               run_low    = '1;
               run_high   = '0;
            end
         end else begin
            norm_beats++;
            r = norm_of(pix);
            pending_norms.push_back(r);
         end
      endtask

      task check_norm_beat(input logic [VAL_W-1:0] value, input logic flat,
                           input logic clip);
         norm_beat_type want;
         if (pending_norms.size() == 0) begin
            report_mismatch($sformatf("result beat %0d/%0b/%0b with nothing expected",
                                      value, flat, clip));
         end else begin
            want = pending_norms.pop_front();
            if (want.clip)
               clip_beats++;
            if (want.flat)
               flat_beats++;
            if (value !== want.value)
               report_mismatch($sformatf("norm_value %0d, expected %0d", value, want.value));
            if (flat !== want.flat)
               report_mismatch($sformatf("flat_range %0b, expected %0b", flat, want.flat));
            if (clip !== want.clip)
               report_mismatch($sformatf("clipped %0b, expected %0b", clip, want.clip));
         end
      endtask
   endclass

   // every block input starts at a known value
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_valid  = 1'b0;
   logic             req_action = ACT_SCAN;
   logic [PIX_W-1:0] req_pixel  = '0;
   logic             req_last   = 1'b0;
   logic             rsp_ready  = 1'b0;
   logic             req_ready;
   logic             rsp_valid;
   logic [VAL_W-1:0] rsp_norm_value;
   logic             rsp_flat_range;
   logic             rsp_clipped;

   norm_scoreboard_type sb;
   int               idle_pct    = 0;   // sender gap chance, only the stimulus reads it
   int               stall_pct   = 0;   // receiver stall chance
   logic             hold_armed  = 1'b0;
   int               beats_sent  = 0;
   int               quiet_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   min_max_pixel_normalizer_top #(
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_pixel      (req_pixel),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_norm_value (rsp_norm_value),
      .rsp_flat_range (rsp_flat_range),
      .rsp_clipped    (rsp_clipped)
   );

   // receiver: random stalls, plus one long hold-off once armed
   always @(posedge clock) begin
      int  hold_count;
      bit  hold_done;
      if (hold_armed && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_count++;
         if (hold_count >= HOLD_CYCLES)
            hold_done = 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor: both channels are sampled at the edge, before any update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_pixel(req_action, req_pixel, req_last);
         if (rsp_valid && rsp_ready)
            sb.check_norm_beat(rsp_norm_value, rsp_flat_range, rsp_clipped);
         // watchdog: cycles without any accepted beat on either side
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_count = 0;
         end else begin
            quiet_count++;
            if (quiet_count >= WATCHDOG_LIMIT) begin
               $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
               $display("min_max_pixel_normalizer_top regression: fail");
               $finish;
            end
         end
      end
   end

   // offer one beat, with random gaps ahead of it, and hold it until taken
   task automatic send_pixel(input logic act, input logic [PIX_W-1:0] pix, input logic lst);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_pixel  <= pix;
      req_last   <= lst;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // short hand-picked sequence: edges of the span, flat frames, ignored last
   task automatic run_directed();
      send_pixel(ACT_NORM, 8'd0,   1'b0);   // nothing latched yet: flat
      send_pixel(ACT_NORM, 8'd255, 1'b1);   // last on a normalize beat is ignored
      send_pixel(ACT_SCAN, 8'd0,   1'b0);
      send_pixel(ACT_SCAN, 8'd255, 1'b1);   // full span 0..255
      send_pixel(ACT_NORM, 8'd0,   1'b0);
      send_pixel(ACT_NORM, 8'd255, 1'b0);
      send_pixel(ACT_NORM, 8'd128, 1'b1);
      send_pixel(ACT_SCAN, 8'd100, 1'b1);   // single pixel frame, zero range
      send_pixel(ACT_NORM, 8'd100, 1'b0);
      send_pixel(ACT_NORM, 8'd3,   1'b0);
      send_pixel(ACT_SCAN, 8'd60,  1'b0);
      send_pixel(ACT_SCAN, 8'd50,  1'b0);
      send_pixel(ACT_SCAN, 8'd55,  1'b1);   // span 50..60
      send_pixel(ACT_NORM, 8'd49,  1'b0);   // just below
      send_pixel(ACT_NORM, 8'd61,  1'b0);   // just above
      send_pixel(ACT_NORM, 8'd50,  1'b0);
      send_pixel(ACT_NORM, 8'd60,  1'b0);
      send_pixel(ACT_NORM, 8'd57,  1'b0);
      send_pixel(ACT_SCAN, 8'd8,   1'b0);
      send_pixel(ACT_SCAN, 8'd7,   1'b1);   // range of one
      send_pixel(ACT_NORM, 8'd8,   1'b0);   // exactly full scale, not clipped
      send_pixel(ACT_NORM, 8'd0,   1'b0);
      send_pixel(ACT_NORM, 8'd255, 1'b0);
      send_pixel(ACT_SCAN, 8'd255, 1'b1);   // min at the top code, zero range
      send_pixel(ACT_NORM, 8'd254, 1'b0);
   endtask

   // the receiver goes quiet while normalize beats keep coming, so the
   // output register and the held quotient fill up and req_ready drops
   task automatic run_backpressure();
      hold_armed <= 1'b1;
      send_pixel(ACT_SCAN, 8'd10,  1'b0);
      send_pixel(ACT_SCAN, 8'd200, 1'b1);
      for (int i = 0; i < 40; i++)
         send_pixel(ACT_NORM, 8'($urandom_range(220, 0)), 1'($urandom_range(1)));
   endtask

   // mostly well-formed frames (scan pass, then normalize pass) with random
   // content; the rest is loose beats that break the frame structure
   task automatic run_frames(input int budget);
      int               stop_at;
      int               n;
      int               m;
      int               pos_lo;
      int               pos_hi;
      int               pick;
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] hi;
      logic [PIX_W-1:0] pix;
      stop_at = beats_sent + budget;
      while (beats_sent < stop_at) begin
         if ($urandom_range(99) < 12) begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
               send_pixel(1'($urandom_range(1)), 8'($urandom_range(255)),
                          $urandom_range(99) < 30);
         end else begin
            // span shape: flat, one or two codes wide, or anything
            pick = $urandom_range(7);
            a    = 8'($urandom_range(255));
            b    = 8'($urandom_range(255));
            if (pick == 0)
               b = a;
            else if (pick == 1)
               b = (a > 8'd253) ? a - 8'($urandom_range(2, 1)) : a + 8'($urandom_range(2, 1));
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            n  = (lo == hi) ? $urandom_range(4, 1) : $urandom_range(8, 2);
            pos_lo = $urandom_range(n - 1);
            pos_hi = (n > 1) ? (pos_lo + $urandom_range(n - 1, 1)) % n : pos_lo;
            for (int i = 0; i < n; i++) begin
               if (i == pos_lo)
                  pix = lo;
               else if (i == pos_hi)
                  pix = hi;
               else
                  pix = 8'($urandom_range(hi, lo));
               send_pixel(ACT_SCAN, pix, i == n - 1);
            end
            m = $urandom_range(12, 1);
            for (int i = 0; i < m; i++) begin
               pick = $urandom_range(99);
               if (pick < 75)
                  pix = 8'($urandom_range(hi, lo));
               else if (pick < 85)
                  pix = $urandom_range(1) ? lo : hi;
               else
                  pix = 8'($urandom_range(255));
               send_pixel(ACT_NORM, pix, $urandom_range(3) == 0);
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // no random idling on either side: directed beats, the long hold-off, then frames
      run_directed();
      run_backpressure();
      run_frames(PHASE_BEATS);
      wait_drained();

      // sender idle 70 percent of the time
      idle_pct = 70;
      run_frames(PHASE_BEATS);
      wait_drained();

      // receiver stalls 70 percent of the time
      idle_pct = 0;
      stall_pct <= 70;
      run_frames(PHASE_BEATS);
      wait_drained();

      // both sides idle 35 percent of the time
      idle_pct = 35;
      stall_pct <= 35;
      run_frames(PHASE_BEATS);
      wait_drained();

      // let any late or spurious result show up before closing
      repeat (2 * NORM_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

      $display("covered %0d scan beats and %0d normalize beats under four idle mixes",
               sb.scan_beats, sb.norm_beats);
      $display("results included %0d clipped and %0d flat-range beats,",
               sb.clip_beats, sb.flat_beats);
      $display("plus one %0d-cycle hold-off", HOLD_CYCLES);
      if (sb.errors == 0)
         $display("min_max_pixel_normalizer_top regression: pass");
      else
         $display("min_max_pixel_normalizer_top regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/mmpn_pkg.sv
rtl/core/mmpn_datapath.sv
rtl/core/mmpn_ctrl.sv
rtl/core/min_max_pixel_normalizer_top.sv
sim/testbench.sv
